@@ hw/rtl/keyed_drop_class_histogram_assert.svh @@
// Assertion macros for the checker file.
`ifndef KEYED_DROP_CLASS_HISTOGRAM_ASSERT_SVH
`define KEYED_DROP_CLASS_HISTOGRAM_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define KDCH_ASSERT_IMPL(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("%m: property failed");
// Next-cycle implication checked outside reset.
`define KDCH_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("%m: property failed");
`endif

@@ hw/rtl/kdch_pkg.sv @@
// Shared constants, types and classification function for the drop histogram.
package kdch_pkg;
    localparam int TableEntries = 16;
    localparam int ClassCount   = 14;
    localparam int SlotW        = $clog2(TableEntries);
    localparam int CntW         = 32;
    localparam int ClassW       = 4;
    localparam int CtrW         = $clog2(TableEntries * ClassCount);

    localparam logic [1:0] ActPacket = 2'd0;
    localparam logic [1:0] ActSweep  = 2'd1;
    localparam logic [1:0] ActExit   = 2'd2;

    localparam logic [15:0] EthLldp = 16'h88CC;
    localparam logic [15:0] EthArp  = 16'h0806;
    localparam logic [15:0] EthIpv4 = 16'h0800;
    localparam logic [15:0] EthIpv6 = 16'h86DD;

    localparam logic [ClassW-1:0] CLldp     = 4'd0;
    localparam logic [ClassW-1:0] CArp      = 4'd1;
    localparam logic [ClassW-1:0] CArpReq   = 4'd2;
    localparam logic [ClassW-1:0] CArpReply = 4'd3;
    localparam logic [ClassW-1:0] CArpOther = 4'd4;
    localparam logic [ClassW-1:0] CIpv4     = 4'd5;
    localparam logic [ClassW-1:0] CIpv6     = 4'd6;
    localparam logic [ClassW-1:0] CTcp      = 4'd7;
    localparam logic [ClassW-1:0] CTcpSyn   = 4'd8;
    localparam logic [ClassW-1:0] CTcpRst   = 4'd9;
    localparam logic [ClassW-1:0] CTcpFin   = 4'd10;
    localparam logic [ClassW-1:0] CUdp      = 4'd11;
    localparam logic [ClassW-1:0] CVrrp     = 4'd12;
    localparam logic [ClassW-1:0] COther    = 4'd13;
    localparam logic [ClassW-1:0] CTotal    = 4'd14;

    localparam logic [1:0] AgeReload = 2'd3;

    // Up to three class counters one packet bumps
    typedef struct packed {
        logic [2:0]        hit;
        logic [ClassW-1:0] cls0;
        logic [ClassW-1:0] cls1;
        logic [ClassW-1:0] cls2;
    } bump_t;

    function automatic bump_t classify(input logic [15:0] et, input logic [15:0] op,
                                       input logic [7:0] proto, input logic fin,
                                       input logic rst, input logic syn);
        bump_t b;
        logic  ip;
        b = '0;
        ip = 1'b0;
        if (et == EthArp) begin
            b.hit  = 3'b011;
            b.cls0 = CArp;
            b.cls1 = (op == 16'd1) ? CArpReq : (op == 16'd2) ? CArpReply : CArpOther;
        end else if (et == EthIpv4) begin
            b.hit = 3'b001; b.cls0 = CIpv4; ip = 1'b1;
        end else if (et == EthIpv6) begin
            b.hit = 3'b001; b.cls0 = CIpv6; ip = 1'b1;
        end else if (et == EthLldp) begin
            b.hit = 3'b001; b.cls0 = CLldp;
        end else begin
            b.hit = 3'b001; b.cls0 = COther;
        end
        if (ip) begin
            if (proto == 8'd6) begin
                b.hit[1] = 1'b1; b.cls1 = CTcp;
                b.hit[2] = fin | rst | syn;
                b.cls2 = fin ? CTcpFin : rst ? CTcpRst : CTcpSyn;
            end else if (proto == 8'd17) begin
                b.hit[1] = 1'b1; b.cls1 = CUdp;
            end else if (proto == 8'd112) begin
                b.hit[1] = 1'b1; b.cls1 = CVrrp;
            end
        end
        return b;
    endfunction
endpackage

@@ hw/rtl/kdch_counter_ram.sv @@
// Class counter memory: one write port, one registered read port.
module kdch_counter_ram (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [kdch_pkg::CtrW-1:0]     wr_addr,
    input  logic [kdch_pkg::CntW-1:0]     wr_data,
    input  logic [kdch_pkg::CtrW-1:0]     rd_addr,
    output logic [kdch_pkg::CntW-1:0]     rd_data
);
    logic [kdch_pkg::CntW-1:0] mem [kdch_pkg::TableEntries*kdch_pkg::ClassCount];

    // Read before write on the same address, read data registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ hw/rtl/keyed_drop_class_histogram.sv @@
// Keyed drop histogram: one item is taken at a time, and s_axis_tready stays low until it
// is done. A packet, an exit or an ignored action first takes a key lookup, one slot
// compare per cycle, then a dispatch step. An exit or an ignored action then ends. A
// packet that finds or allocates a slot then reads and writes one counter per class
// bumped (one to three classes); an allocation first clears the slot's 14 counters, one
// per cycle. A reported sweep streams 15 results, each one counter read, one load into
// the output register and a bus transfer that waits while m_axis_tready is low, then
// ages the slot. An unreported sweep of a used slot only ages it; a sweep of a free slot
// ends on accept. The single key comparator and the counter memory, with one write and
// one read port, set this sequencing. No clearing pass is needed after reset.
module keyed_drop_class_histogram (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: action[1:0], key_high[65:2], key_low[129:66], key_is_v6[130],
    // ethertype[146:131], arp_opcode[162:147], ip_protocol[170:163], tcp_fin[171],
    // tcp_rst[172], tcp_syn[173], slot_index[177:174], zero fill to 184
    input  logic [183:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: report_key_high[63:0], report_key_low[127:64], report_is_v6[128],
    // report_dead[129], class_index[133:130], class_count[165:134], zero fill to 168
    output logic [167:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);
    localparam int SlotW = kdch_pkg::SlotW;
    localparam int CntW  = kdch_pkg::CntW;
    localparam int SCntW = $clog2(kdch_pkg::TableEntries + 1);

    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StSearch = 3'd1;
    localparam logic [2:0] StClear  = 3'd2;
    localparam logic [2:0] StRead   = 3'd3;
    localparam logic [2:0] StWrite  = 3'd4;
    localparam logic [2:0] StRepRd  = 3'd5;
    localparam logic [2:0] StRepOut = 3'd6;
    localparam logic [2:0] StAge    = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [183:0]     item_reg;
    logic [31:0]      thresh_reg;
    logic [SCntW-1:0] scan_reg;
    logic             found_reg, free_ok_reg;
    logic [SlotW-1:0] hit_slot_reg, free_slot_reg, slot_reg;
    logic [3:0]       cls_reg;
    logic [1:0]       bump_reg;
    logic             tvalid_reg;
    logic [167:0]     tdata_reg;
    logic             tlast_reg;

    logic [kdch_pkg::TableEntries-1:0] used_reg, dead_reg;
    logic [63:0] key_hi_mem [kdch_pkg::TableEntries];
    logic [63:0] key_lo_mem [kdch_pkg::TableEntries];
    logic        v6_mem     [kdch_pkg::TableEntries];
    logic [CntW-1:0] total_reg [kdch_pkg::TableEntries];
    logic [1:0]  age_reg    [kdch_pkg::TableEntries];

    logic [1:0]  act;
    logic [63:0] khi, klo;
    logic [SlotW-1:0] scan_slot;
    kdch_pkg::bump_t bmp;
    logic [kdch_pkg::ClassW-1:0] cur_cls;
    logic        bump_done;

    logic                       ram_we;
    logic [kdch_pkg::CtrW-1:0]  ram_wa, ram_ra;
    logic [CntW-1:0]            ram_wd, ram_rd;

    assign act  = item_reg[1:0];
    assign khi  = item_reg[65:2];
    assign klo  = item_reg[129:66];
    assign scan_slot = scan_reg[SlotW-1:0];
    assign bmp = kdch_pkg::classify(item_reg[146:131], item_reg[162:147],
                                    item_reg[170:163], item_reg[171], item_reg[172],
                                    item_reg[173]);

    // Pick the class for the current bump step
    always_comb begin
        case (bump_reg)
            2'd0:    cur_cls = bmp.cls0;
            2'd1:    cur_cls = bmp.cls1;
            default: cur_cls = bmp.cls2;
        endcase
    end

    // Last bump step when no further class is hit
    always_comb begin
        case (bump_reg)
            2'd0:    bump_done = !bmp.hit[1];
            2'd1:    bump_done = !bmp.hit[2];
            default: bump_done = 1'b1;
        endcase
    end

    assign s_axis_tready = (state_reg == StIdle) && !tvalid_reg;
    assign cfg_ready     = (state_reg == StIdle) && !s_axis_tvalid;
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tlast  = tlast_reg;

    // Counter memory address: slot * 14 + class
    always_comb begin
        ram_ra = kdch_pkg::CtrW'(slot_reg * kdch_pkg::ClassCount)
               + kdch_pkg::CtrW'((state_reg == StRepRd) ? cls_reg : cur_cls);
        ram_wa = kdch_pkg::CtrW'(slot_reg * kdch_pkg::ClassCount)
               + kdch_pkg::CtrW'((state_reg == StWrite) ? cur_cls : cls_reg);
        ram_we = 1'b0;
        ram_wd = '0;
        if (state_reg == StClear) begin
            ram_we = 1'b1;
        end else if (state_reg == StWrite) begin
            ram_we = 1'b1;
            ram_wd = ram_rd + 1'b1;
        end else if (state_reg == StRepOut && m_axis_tready && tvalid_reg
                     && cls_reg != kdch_pkg::CTotal) begin
            ram_we = 1'b1;
        end
    end

    kdch_counter_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            // Take an item; a sweep skips the lookup
            StIdle:   if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tdata[1:0] == kdch_pkg::ActSweep) begin
                    if (32'(s_axis_tdata[177:174]) < 32'(kdch_pkg::TableEntries)
                        && used_reg[s_axis_tdata[174 +: SlotW]]) begin
                        state_next = (total_reg[s_axis_tdata[174 +: SlotW]] >= thresh_reg)
                                   ? StRepRd : StAge;
                    end
                end else begin
                    state_next = StSearch;
                end
            end
            StSearch: if (scan_reg == SCntW'(kdch_pkg::TableEntries)) begin
                state_next = StIdle;
            end
            StClear:  if (cls_reg == kdch_pkg::COther) begin
                state_next = StRead;
            end
            StRead:   state_next = StWrite;
            StWrite:  if (bump_done) begin
                state_next = StIdle;
            end else begin
                state_next = StRead;
            end
            StRepRd:  state_next = StRepOut;
            StRepOut: if (tvalid_reg && m_axis_tready) begin
                state_next = (cls_reg == kdch_pkg::CTotal) ? StAge : StRepRd;
            end
            StAge:    state_next = StIdle;
            default:  state_next = StIdle;
        endcase
        // Lookup finished: dispatch by action
        if (state_reg == StSearch && scan_reg == SCntW'(kdch_pkg::TableEntries)) begin
            if (act == kdch_pkg::ActPacket) begin
                if (found_reg) state_next = StRead;
                else if (free_ok_reg) state_next = StClear;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= StIdle;
            thresh_reg <= 32'd1;
            used_reg   <= '0;
            tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                thresh_reg <= cfg_data;
            end
            unique case (state_reg)
                // Take an item
                StIdle: if (s_axis_tvalid && s_axis_tready) begin
                    item_reg    <= s_axis_tdata;
                    scan_reg    <= '0;
                    found_reg   <= 1'b0;
                    free_ok_reg <= 1'b0;
                    bump_reg    <= 2'd0;
                    cls_reg     <= '0;
                    slot_reg    <= s_axis_tdata[174 +: SlotW];
                end
                // Compare one slot per cycle
                StSearch: begin
                    if (scan_reg != SCntW'(kdch_pkg::TableEntries)) begin
                        scan_reg <= scan_reg + 1'b1;
                        if (used_reg[scan_slot] && key_hi_mem[scan_slot] == khi
                            && key_lo_mem[scan_slot] == klo && !found_reg) begin
                            found_reg    <= 1'b1;
                            hit_slot_reg <= scan_slot;
                        end
                        if (!used_reg[scan_slot] && !free_ok_reg) begin
                            free_ok_reg   <= 1'b1;
                            free_slot_reg <= scan_slot;
                        end
                    end else if (found_reg) begin
                        slot_reg <= hit_slot_reg;
                        if (act == kdch_pkg::ActExit) begin
                            dead_reg[hit_slot_reg] <= 1'b1;
                        end else if (act == kdch_pkg::ActPacket) begin
                            total_reg[hit_slot_reg] <= total_reg[hit_slot_reg] + 1'b1;
                        end
                    end else if (act == kdch_pkg::ActPacket && free_ok_reg) begin
                        // Allocate the lowest free slot
                        slot_reg                  <= free_slot_reg;
                        used_reg[free_slot_reg]   <= 1'b1;
                        key_hi_mem[free_slot_reg] <= khi;
                        key_lo_mem[free_slot_reg] <= klo;
                        v6_mem[free_slot_reg]     <= item_reg[130];
                        total_reg[free_slot_reg]  <= 32'd1;
                        age_reg[free_slot_reg]    <= 2'd0;
                        dead_reg[free_slot_reg]   <= 1'b0;
                    end
                end
                // Zero one counter per cycle
                StClear: begin
                    cls_reg <= (cls_reg == kdch_pkg::COther) ? '0 : cls_reg + 1'b1;
                end
                StRead: begin
                end
                StWrite: begin
                    bump_reg <= bump_reg + 1'b1;
                end
                // Read one class counter for the next result
                StRepRd: begin
                end
                StRepOut: begin
                    if (!tvalid_reg) begin
                        tvalid_reg <= 1'b1;
                        tlast_reg  <= (cls_reg == kdch_pkg::CTotal);
                        tdata_reg  <= {2'b00,
                                       (cls_reg == kdch_pkg::CTotal) ? total_reg[slot_reg]
                                                                     : ram_rd,
                                       cls_reg, dead_reg[slot_reg], v6_mem[slot_reg],
                                       key_lo_mem[slot_reg], key_hi_mem[slot_reg]};
                    end else if (m_axis_tready) begin
                        tvalid_reg <= 1'b0;
                        cls_reg    <= cls_reg + 1'b1;
                    end
                end
                // Age the slot, clear its total and free it when dead
                StAge: begin
                    total_reg[slot_reg] <= '0;
                    if (total_reg[slot_reg] != '0) begin
                        age_reg[slot_reg] <= kdch_pkg::AgeReload;
                        if (dead_reg[slot_reg]) used_reg[slot_reg] <= 1'b0;
                    end else begin
                        age_reg[slot_reg] <= age_reg[slot_reg] - 1'b1;
                        if (age_reg[slot_reg] == 2'd1) dead_reg[slot_reg] <= 1'b1;
                        if (dead_reg[slot_reg] || age_reg[slot_reg] == 2'd1) begin
                            used_reg[slot_reg] <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

@@ hw/rtl/kdch_checker.sv @@
// Port checker for the drop histogram, bound to the top level.
`include "keyed_drop_class_histogram_assert.svh"
module kdch_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [167:0] m_axis_tdata,
    input logic         m_axis_tlast,
    input logic         cfg_valid,
    input logic         cfg_ready
);
    // tlast marks exactly the total result
    `KDCH_ASSERT_IMPL(a_last_total, aclk, aresetn, m_axis_tvalid,
        m_axis_tlast == (m_axis_tdata[133:130] == kdch_pkg::CTotal))
    // no item taken while a result waits
    `KDCH_ASSERT_IMPL(a_no_take_busy, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    // a stalled result holds
    `KDCH_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    // threshold written only with no item offered and no result waiting
    `KDCH_ASSERT_IMPL(a_cfg_idle, aclk, aresetn, cfg_valid && cfg_ready,
        !s_axis_tvalid && !m_axis_tvalid)
endmodule

bind keyed_drop_class_histogram kdch_checker u_kdch_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

@@ dv/keyed_drop_class_histogram_tb.sv @@
// Self-checking testbench for the keyed drop-class histogram table.
module keyed_drop_class_histogram_tb;

    localparam logic [1:0] ActIgnored = 2'd3;
    localparam int         DrainCycles = 80;
    localparam int         StallLimit  = 20000;

    typedef struct {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic        is_v6;
        logic        dead;
        logic [3:0]  cls;
        logic [31:0] count;
        logic        last;
    } report_beat_t;

    // Table predictor plus the queue of report beats still owed by the block
    class histogram_scoreboard;
        logic [31:0]  threshold;
        logic         used [kdch_pkg::TableEntries];
        logic [63:0]  kh [kdch_pkg::TableEntries];
        logic [63:0]  kl [kdch_pkg::TableEntries];
        logic         v6 [kdch_pkg::TableEntries];
        logic [31:0]  total [kdch_pkg::TableEntries];
        logic [31:0]  cnt [kdch_pkg::TableEntries][kdch_pkg::ClassCount];
        logic [1:0]   age [kdch_pkg::TableEntries];
        logic         dead [kdch_pkg::TableEntries];
        report_beat_t pending [$];
        int           errors;
        int           beats_seen;
        int           reports_seen;

        function void clear_table();
            threshold = 32'd1;
            errors = 0;
            beats_seen = 0;
            reports_seen = 0;
            for (int s = 0; s < kdch_pkg::TableEntries; s++) begin
                used[s] = 1'b0;
                total[s] = '0;
                age[s] = '0;
                dead[s] = 1'b0;
                for (int c = 0; c < kdch_pkg::ClassCount; c++) cnt[s][c] = '0;
            end
        endfunction

        function int lookup(logic [63:0] h, logic [63:0] l);
            for (int s = 0; s < kdch_pkg::TableEntries; s++)
                if (used[s] && kh[s] == h && kl[s] == l) return s;
            return -1;
        endfunction

        function void count_transport(int s, logic [7:0] proto, logic fin, logic rst,
                                      logic syn);
            if (proto == 8'd6) begin
                cnt[s][kdch_pkg::CTcp]++;
                if (fin) cnt[s][kdch_pkg::CTcpFin]++;
                else if (rst) cnt[s][kdch_pkg::CTcpRst]++;
                else if (syn) cnt[s][kdch_pkg::CTcpSyn]++;
            end else if (proto == 8'd17) begin
                cnt[s][kdch_pkg::CUdp]++;
            end else if (proto == 8'd112) begin
                cnt[s][kdch_pkg::CVrrp]++;
            end
        endfunction

        // Update the table for one accepted item and queue its report beats
        function void note_item(logic [183:0] d);
            logic [1:0]  act;
            logic [63:0] h, l;
            logic [15:0] et, op;
            logic [7:0]  proto;
            int          s;
            report_beat_t b;
            act = d[1:0];
            h = d[65:2];
            l = d[129:66];
            et = d[146:131];
            op = d[162:147];
            proto = d[170:163];
            s = lookup(h, l);
            if (act == kdch_pkg::ActPacket) begin
                for (int i = 0; i < kdch_pkg::TableEntries && s < 0; i++)
                    if (!used[i]) begin
                        s = i;
                        used[i] = 1'b1;
                        kh[i] = h;
                        kl[i] = l;
                        v6[i] = d[130];
                        total[i] = '0;
                        age[i] = '0;
                        dead[i] = 1'b0;
                        for (int c = 0; c < kdch_pkg::ClassCount; c++) cnt[i][c] = '0;
                    end
                if (s < 0) return;
                total[s]++;
                if (et == kdch_pkg::EthArp) begin
                    cnt[s][kdch_pkg::CArp]++;
                    if (op == 16'd1) cnt[s][kdch_pkg::CArpReq]++;
                    else if (op == 16'd2) cnt[s][kdch_pkg::CArpReply]++;
                    else cnt[s][kdch_pkg::CArpOther]++;
                end else if (et == kdch_pkg::EthIpv4) begin
                    cnt[s][kdch_pkg::CIpv4]++;
                    count_transport(s, proto, d[171], d[172], d[173]);
                end else if (et == kdch_pkg::EthIpv6) begin
                    cnt[s][kdch_pkg::CIpv6]++;
                    count_transport(s, proto, d[171], d[172], d[173]);
                end else if (et == kdch_pkg::EthLldp) begin
                    cnt[s][kdch_pkg::CLldp]++;
                end else begin
                    cnt[s][kdch_pkg::COther]++;
                end
            end else if (act == kdch_pkg::ActExit) begin
                if (s >= 0) dead[s] = 1'b1;
            end else if (act == kdch_pkg::ActSweep) begin
                s = int'(d[177:174]);
                if (s >= kdch_pkg::TableEntries || !used[s]) return;
                if (total[s] >= threshold) begin
                    for (int c = 0; c <= kdch_pkg::ClassCount; c++) begin
                        b.key_high = kh[s];
                        b.key_low = kl[s];
                        b.is_v6 = v6[s];
                        b.dead = dead[s];
                        b.cls = 4'(c);
                        b.count = (c < kdch_pkg::ClassCount) ? cnt[s][c] : total[s];
                        b.last = (c == kdch_pkg::ClassCount);
                        pending.push_back(b);
                        if (c < kdch_pkg::ClassCount) cnt[s][c] = '0;
                    end
                end
                if (total[s] != 0) begin
                    age[s] = kdch_pkg::AgeReload;
                end else begin
                    age[s] = age[s] - 2'd1;
                    if (age[s] == 2'd0) dead[s] = 1'b1;
                end
                total[s] = '0;
                if (dead[s]) used[s] = 1'b0;
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("MISMATCH beat %0d: %s got %0h want %0h", beats_seen, what, got, want);
        endtask

        // Compare one accepted report beat with the oldest one owed
        task check_beat(logic [167:0] d, logic last);
            report_beat_t e;
            beats_seen++;
            if (pending.size() == 0) begin
                report("unexpected beat, class", 64'(d[133:130]), 64'd0);
                return;
            end
            e = pending.pop_front();
            if (d[63:0] !== e.key_high) report("key_high", d[63:0], e.key_high);
            if (d[127:64] !== e.key_low) report("key_low", d[127:64], e.key_low);
            if (d[128] !== e.is_v6) report("is_v6", 64'(d[128]), 64'(e.is_v6));
            if (d[129] !== e.dead) report("dead", 64'(d[129]), 64'(e.dead));
            if (d[133:130] !== e.cls) begin
                report("class_index", 64'(d[133:130]), 64'(e.cls));
            end
            if (d[165:134] !== e.count) begin
                report("class_count", 64'(d[165:134]), 64'(e.count));
            end
            if (last !== e.last) report("tlast", 64'(last), 64'(e.last));
            if (e.last) reports_seen++;
        endtask
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [183:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;

    histogram_scoreboard sb;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles = 0;
    int          items_sent;
    logic [63:0] key_pool_high [24];
    logic [63:0] key_pool_low [24];

    always #2 aclk = ~aclk;

    keyed_drop_class_histogram dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Check report beats and randomize the receiver stall
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Abort when no channel moves for too long
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("keyed_drop_class_histogram_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [183:0] pack_item(logic [1:0] act, logic [63:0] h, logic [63:0] l,
            logic v6, logic [15:0] et, logic [15:0] op, logic [7:0] proto,
            logic fin, logic rst, logic syn, logic [3:0] slot);
        return {6'd0, slot, syn, rst, fin, proto, op, et, v6, l, h, act};
    endfunction

    // Hold one item on the input until it is taken, with an optional gap first
    task send_item(logic [183:0] d);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_item(d);
        items_sent++;
    endtask

    task write_threshold(logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.threshold = value;
        cfg_valid <= 1'b0;
    endtask

    // Wait for all owed beats, then let any in-flight lookup finish
    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task send_random(int n);
        int          pick, k;
        logic [1:0]  act;
        logic [63:0] h, l;
        logic [15:0] et, op;
        logic [7:0]  proto;
        for (int i = 0; i < n; i++) begin
            pick = int'($urandom_range(99));
            act = (pick < 55) ? kdch_pkg::ActPacket : (pick < 85) ? kdch_pkg::ActSweep :
                  (pick < 95) ? kdch_pkg::ActExit : ActIgnored;
            k = int'($urandom_range(23));
            h = key_pool_high[k];
            l = key_pool_low[k];
            if ($urandom_range(9) == 0) begin
                h = {$urandom, $urandom};
                l = {$urandom, $urandom};
            end
            case ($urandom_range(5))
                0: et = kdch_pkg::EthArp;
                1: et = kdch_pkg::EthIpv4;
                2: et = kdch_pkg::EthIpv6;
                3: et = kdch_pkg::EthLldp;
                default: et = 16'($urandom);
            endcase
            op = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(2, 1));
            case ($urandom_range(4))
                0: proto = 8'd6;
                1: proto = 8'd17;
                2: proto = 8'd112;
                3: proto = 8'd6;
                default: proto = 8'($urandom);
            endcase
            send_item(pack_item(act, h, l, 1'($urandom), et, op, proto, 1'($urandom),
                                1'($urandom), 1'($urandom), 4'($urandom)));
        end
    endtask

    initial begin
        logic [63:0] ones;
        sb = new();
        sb.clear_table();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        ones = '1;
        for (int i = 0; i < 24; i++) begin
            key_pool_high[i] = {$urandom, $urandom};
            key_pool_low[i] = {$urandom, $urandom};
        end
        key_pool_high[0] = '0;
        key_pool_low[0] = '0;
        key_pool_high[1] = ones;
        key_pool_low[1] = ones;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every class on the all-zero key, extremes on the all-ones key
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b0, kdch_pkg::EthLldp, 16'd0,
                            8'd0, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b1, kdch_pkg::EthArp, 16'd1,
                            8'd0, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b0, kdch_pkg::EthArp, 16'd2,
                            8'd0, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b0, kdch_pkg::EthArp, 16'hFFFF,
                            8'd0, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b0, kdch_pkg::EthIpv4, 16'd0,
                            8'd6, 1'b1, 1'b1, 1'b1, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b0, kdch_pkg::EthIpv4, 16'd0,
                            8'd6, 1'b0, 1'b1, 1'b1, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b0, kdch_pkg::EthIpv6, 16'd0,
                            8'd6, 1'b0, 1'b0, 1'b1, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b0, kdch_pkg::EthIpv6, 16'd0,
                            8'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b0, kdch_pkg::EthIpv4, 16'd0,
                            8'd17, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b0, kdch_pkg::EthIpv6, 16'd0,
                            8'd112, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b0, kdch_pkg::EthIpv4, 16'd0,
                            8'hFF, 1'b1, 1'b1, 1'b1, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, '0, '0, 1'b0, 16'hFFFF, 16'd0,
                            8'd0, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActPacket, ones, ones, 1'b1, kdch_pkg::EthIpv6,
                            16'hFFFF, 8'd17, 1'b1, 1'b1, 1'b1, 4'hF));
        send_item(pack_item(ActIgnored, ones, ones, 1'b1, kdch_pkg::EthIpv4, 16'd0,
                            8'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActSweep, '0, '0, 1'b0, 16'd0, 16'd0,
                            8'd0, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActSweep, '0, '0, 1'b0, 16'd0, 16'd0,
                            8'd0, 1'b0, 1'b0, 1'b0, 4'd15));
        // Exit, then sweep: reported as dead and freed
        send_item(pack_item(kdch_pkg::ActExit, ones, ones, 1'b0, 16'd0, 16'd0,
                            8'd0, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActExit, 64'd5, 64'd7, 1'b0, 16'd0, 16'd0,
                            8'd0, 1'b0, 1'b0, 1'b0, 4'd0));
        send_item(pack_item(kdch_pkg::ActSweep, '0, '0, 1'b0, 16'd0, 16'd0,
                            8'd0, 1'b0, 1'b0, 1'b0, 4'd1));
        // Idle slot ages out over three quiet sweeps
        for (int i = 0; i < 4; i++)
            send_item(pack_item(kdch_pkg::ActSweep, '0, '0, 1'b0, 16'd0, 16'd0,
                                8'd0, 1'b0, 1'b0, 1'b0, 4'd0));
        drain();

        write_threshold(32'd2);
        send_idle_pct = 21;
        recv_stall_pct = 74;
        send_random(80);
        drain();

        write_threshold(32'hFFFF_FFFF);
        send_idle_pct = 74;
        recv_stall_pct = 21;
        send_random(20);
        drain();

        write_threshold(32'd1);
        send_random(70);
        drain();

        write_threshold(32'd3);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(40);
        drain();

        $display("Covered %0d items over thresholds 1, 2, 3 and all-ones;", items_sent);
        $display("checked %0d report beats in %0d reports.", sb.beats_seen, sb.reports_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("keyed_drop_class_histogram_tb passed");
        end else begin
            $display("keyed_drop_class_histogram_tb failed");
        end
        $finish;
    end
endmodule

@@ keyed_drop_class_histogram.f @@
+incdir+hw/rtl
hw/rtl/kdch_pkg.sv
hw/rtl/kdch_counter_ram.sv
hw/rtl/keyed_drop_class_histogram.sv
hw/rtl/kdch_checker.sv
dv/keyed_drop_class_histogram_tb.sv
